/* rtl/lmbp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmbp_pkg
// Shared widths, codes, reset values and fixed point helpers for the
// logistic map bifurcation plotter.
// ----------------------------------------------------------------------------
package lmbp_pkg;

    // field widths of the item, result and configuration channels
    localparam int ACT_W      = 2;
    localparam int COL_W      = 9;
    localparam int ROW_W      = 8;
    localparam int BRT_W      = 8;
    localparam int CNT_W      = 16;
    localparam int LIM_W      = 8;
    localparam int Q_W        = 32;
    localparam int CFG_IDX_W  = 3;

    // fraction bits of map values and of the row scale product
    localparam int FRAC_W     = 24;
    localparam int ROW_FRAC_W = 40;

    // item actions
    typedef logic [ACT_W-1:0] t_action;
    localparam t_action ACT_RENDER = 2'd0;
    localparam t_action ACT_READ   = 2'd1;
    localparam t_action ACT_CLEAR  = 2'd2;

    // configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_CENTER_X   = 3'd0;
    localparam t_cfg_idx CFG_CENTER_Y   = 3'd1;
    localparam t_cfg_idx CFG_PPU        = 3'd2;
    localparam t_cfg_idx CFG_UPP        = 3'd3;
    localparam t_cfg_idx CFG_WARMUP     = 3'd4;
    localparam t_cfg_idx CFG_REC_COUNT  = 3'd5;
    localparam t_cfg_idx CFG_MISS_LIMIT = 3'd6;

    // signed Q8.24 value
    typedef logic signed [Q_W-1:0] t_q;
    localparam t_q Q_ONE  = 32'sh0100_0000;
    localparam t_q Q_HALF = 32'sh0080_0000;

    // configuration reset values
    localparam t_q               RST_CENTER_X   = 32'sd16777216;
    localparam t_q               RST_CENTER_Y   = 32'sd9227469;
    localparam logic [Q_W-1:0]   RST_PPU        = 32'd13107200;
    localparam logic [Q_W-1:0]   RST_UPP        = 32'd83886;
    localparam logic [CNT_W-1:0] RST_WARMUP     = 16'd1000;
    localparam logic [CNT_W-1:0] RST_REC_COUNT  = 16'd1000;
    localparam logic [LIM_W-1:0] RST_MISS_LIMIT = 8'd80;

    // saturation bounds in 64 bits
    localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

    // controller states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_SETUP,
        S_MA,
        S_MB,
        S_DRAIN,
        S_READ,
        S_READ_WAIT,
        S_RESULT
    } t_state;

    // clamp a 64-bit signed value into Q8.24
    function automatic t_q sat_q(input logic signed [63:0] x);
        t_q res;
        if (x > SAT_MAX) begin
            res = SAT_MAX[Q_W-1:0];
        end else if (x < SAT_MIN) begin
            res = SAT_MIN[Q_W-1:0];
        end else begin
            res = x[Q_W-1:0];
        end
        return res;
    endfunction

    // min(255, floor(old*12/10) + 10), divide by ten via reciprocal 3277/2^15
    function automatic logic [BRT_W-1:0] bright_next(input logic [BRT_W-1:0] old);
        logic [11:0] x12;
        logic [23:0] prod;
        logic [8:0]  nv;
        x12  = 12'(old) * 12'd12;
        prod = 24'(x12) * 24'd3277;
        nv   = 9'(prod >> 15) + 9'd10;
        return (nv > 9'd255) ? 8'hFF : nv[7:0];
    endfunction

endpackage
`default_nettype wire

/* rtl/lmbp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmbp_if
// Valid/ready channels of the plotter: work items in, results out and
// configuration register writes.
// ----------------------------------------------------------------------------

// work item channel
interface lmbp_item_if import lmbp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;

    modport source (output valid, action, column, row, input ready);
    modport sink   (input valid, action, column, row, output ready);
endinterface

// result channel
interface lmbp_res_if import lmbp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [BRT_W-1:0] brightness;
    logic [CNT_W-1:0] points_drawn;

    modport source (output valid, brightness, points_drawn, input ready);
    modport sink   (input valid, brightness, points_drawn, output ready);
endinterface

// configuration write channel
interface lmbp_cfg_if import lmbp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [Q_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/lmbp_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmbp_ram
// Generic single port synchronous RAM, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module lmbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* rtl/logistic_map_bifurcation_plotter.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// logistic_map_bifurcation_plotter
// Renders columns of a logistic map bifurcation diagram into an image RAM.
// ----------------------------------------------------------------------------
// Channels: i_item takes one item at a time (render column, read pixel,
// clear image); o_res returns exactly one result per item; i_cfg writes the
// seven setup registers and is always ready, writes belong between items.
// Work per item, from accept to result valid:
//   render : a restoring divider for the window height forms a quotient of
//            QW = 40 + bits(IMAGE_HEIGHT/2) bits (48 at 256 rows), then the
//            map runs its warmup steps and then the recording phase; each
//            map step takes two registered 32x32 multiplies. Pixel updates
//            run beside the loop on the RAM port, and a pending one is
//            drained before the result.
//   read   : one RAM read; out of range reads and unknown actions go
//            straight to the result
//   clear  : all IMAGE_WIDTH*IMAGE_HEIGHT pixels, one pixel per cycle
// One item is in work at a time; the next is taken as soon as the current
// result sits in the output register, even while the receiver stalls it.
// Reset: the configuration registers return to their defaults and a clearing
// pass over all IMAGE_WIDTH*IMAGE_HEIGHT pixels (131072 by default) blackens
// the image before the first item is accepted.
// ----------------------------------------------------------------------------
module logistic_map_bifurcation_plotter import lmbp_pkg::*; #(
    parameter int IMAGE_WIDTH  = 512,
    parameter int IMAGE_HEIGHT = 256
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lmbp_item_if.sink  i_item,
    lmbp_cfg_if.sink   i_cfg,
    lmbp_res_if.source o_res
);

    localparam int HALF_W   = IMAGE_WIDTH / 2;
    localparam int HALF_H   = IMAGE_HEIGHT / 2;
    localparam int DEPTH    = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int AW       = $clog2(DEPTH);
    localparam int HB       = $clog2(HALF_H + 1);
    localparam int QW       = HB + ROW_FRAC_W;
    localparam int DCNT_W   = $clog2(QW);
    localparam int DCOL_W   = 14;
    localparam int PROW_W   = 27;
    localparam int RANGE_W  = 14;
    localparam logic [QW-1:0] DIVIDEND = {HB'(HALF_H), {ROW_FRAC_W{1'b0}}};

    // controller and sequencing state
    t_state           r_state, n_state;
    logic [AW-1:0]    r_clr_addr, n_clr_addr;
    logic             r_clr_reply, n_clr_reply;
    logic             r_first, n_first;
    logic             r_last_rec, n_last_rec;
    logic [CNT_W-1:0] r_steps, n_steps;
    logic [CNT_W-1:0] r_recs, n_recs;
    logic [CNT_W-1:0] r_drawn, n_drawn;
    logic [LIM_W:0]   r_miss, n_miss;
    logic             r_pix_p, n_pix_p;
    logic             r_pix_w, n_pix_w;
    logic             r_out_valid, n_out_valid;

    // configuration registers
    t_q               r_center_x, r_center_y;
    logic [Q_W-1:0]   r_ppu, r_upp;
    logic [CNT_W-1:0] r_warmup, r_rec_count;
    logic [LIM_W-1:0] r_miss_limit;

    // datapath registers
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [QW-1:0]     r_divq, n_divq;
    logic [Q_W-1:0]    r_rem, n_rem;
    logic [DCNT_W-1:0] r_dcnt, n_dcnt;
    t_q                r_min, n_min, r_max, n_max, r_r, n_r;
    t_q                r_z, n_z, r_rest, n_rest;
    logic signed [63:0] r_p1, n_p1, r_p2, n_p2;
    logic [64:0]       r_prod, n_prod;
    logic              r_neg, n_neg;
    logic [AW-1:0]     r_waddr, n_waddr;
    logic [BRT_W-1:0]  r_res_b, n_res_b, r_out_b, n_out_b;
    logic [CNT_W-1:0]  r_res_p, n_res_p, r_out_p, n_out_p;

    // combinational helpers
    logic [Q_W-1:0]     ppu_eff;
    logic               col_ok, row_ok;
    logic [AW-1:0]      rd_addr, pix_addr;
    logic [Q_W:0]       div_trial;
    logic               div_ge;
    logic signed [DCOL_W-1:0] dcol;
    t_q                 z_cur, q1;
    logic signed [Q_W:0] d;
    logic [Q_W:0]       mag;
    logic               in_win;
    logic [CNT_W-1:0]   mb_recs;
    logic [24:0]        t_row;
    logic signed [PROW_W-1:0] prow;
    logic               pix_in;
    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic [BRT_W-1:0]   ram_wdata, ram_rdata;
    logic               item_ready;

    // image store
    lmbp_ram #(
        .WIDTH (BRT_W),
        .DEPTH (DEPTH)
    ) u_image (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // handshake outputs
    assign i_item.ready       = item_ready;
    assign i_cfg.ready        = 1'b1;
    assign o_res.valid        = r_out_valid;
    assign o_res.brightness   = r_out_b;
    assign o_res.points_drawn = r_out_p;

    // address and range helpers
    assign ppu_eff = (r_ppu == '0) ? Q_W'(1) : r_ppu;
    assign col_ok  = RANGE_W'(i_item.column) < RANGE_W'(IMAGE_WIDTH);
    assign row_ok  = RANGE_W'(i_item.row) < RANGE_W'(IMAGE_HEIGHT);
    assign rd_addr = AW'(r_row) * AW'(IMAGE_WIDTH) + AW'(r_col);

    // one restoring division step for the window half height
    assign div_trial = {r_rem, r_divq[QW-1]};
    assign div_ge    = div_trial >= {1'b0, ppu_eff};

    // growth rate offset of the column
    assign dcol = $signed(DCOL_W'(r_col)) - $signed(DCOL_W'(HALF_W));

    // map step halves
    assign z_cur = r_first ? Q_HALF : sat_q(r_p2 >>> FRAC_W);
    assign q1    = sat_q(r_p1 >>> FRAC_W);

    // window test and distance from the centre row
    assign d      = (Q_W + 1)'(r_z) - (Q_W + 1)'(r_center_y);
    assign mag    = d[Q_W] ? (Q_W + 1)'(-d) : (Q_W + 1)'(d);
    assign in_win = (r_min < r_z) && (r_z < r_max);

    // pixel row from the registered scale product
    assign t_row    = r_prod[64:40];
    assign prow     = r_neg ? PROW_W'(HALF_H) + PROW_W'(t_row)
                            : PROW_W'(HALF_H) - PROW_W'(t_row);
    assign pix_in   = !prow[PROW_W-1] && ($unsigned(prow) < PROW_W'(IMAGE_HEIGHT));
    assign pix_addr = AW'(prow) * AW'(IMAGE_WIDTH) + AW'(r_col);

    // next state, datapath and memory port
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_clr_reply = r_clr_reply;
        n_first     = r_first;
        n_last_rec  = r_last_rec;
        n_steps     = r_steps;
        n_recs      = r_recs;
        n_drawn     = r_drawn;
        n_miss      = r_miss;
        n_pix_p     = 1'b0;
        n_pix_w     = 1'b0;
        n_out_valid = r_out_valid;
        n_col       = r_col;
        n_row       = r_row;
        n_divq      = r_divq;
        n_rem       = r_rem;
        n_dcnt      = r_dcnt;
        n_min       = r_min;
        n_max       = r_max;
        n_r         = r_r;
        n_z         = r_z;
        n_rest      = r_rest;
        n_p1        = r_p1;
        n_p2        = r_p2;
        n_prod      = r_prod;
        n_neg       = r_neg;
        n_waddr     = r_waddr;
        n_res_b     = r_res_b;
        n_res_p     = r_res_p;
        n_out_b     = r_out_b;
        n_out_p     = r_out_p;
        mb_recs     = r_recs;
        ram_we      = 1'b0;
        ram_addr    = rd_addr;
        ram_wdata   = '0;
        item_ready  = 1'b0;

        // output register drains when taken
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                ram_we     = 1'b1;
                ram_addr   = r_clr_addr;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_clr_addr  = '0;
                    n_clr_reply = 1'b0;
                    n_state     = r_clr_reply ? S_RESULT : S_IDLE;
                end
            end

            S_IDLE: begin
                item_ready = 1'b1;
                if (i_item.valid) begin
                    n_col   = i_item.column;
                    n_row   = i_item.row;
                    n_res_b = '0;
                    n_res_p = '0;
                    unique case (t_action'(i_item.action))
                        ACT_RENDER: begin
                            if (col_ok) begin
                                n_divq     = DIVIDEND;
                                n_rem      = '0;
                                n_dcnt     = '0;
                                n_first    = 1'b1;
                                n_last_rec = 1'b0;
                                n_steps    = '0;
                                n_recs     = '0;
                                n_drawn    = '0;
                                n_miss     = '0;
                                n_state    = S_DIV;
                            end else begin
                                n_state = S_RESULT;
                            end
                        end
                        ACT_READ: begin
                            n_state = (col_ok && row_ok) ? S_READ : S_RESULT;
                        end
                        ACT_CLEAR: begin
                            n_clr_addr  = '0;
                            n_clr_reply = 1'b1;
                            n_state     = S_CLEAR;
                        end
                        default: begin
                            n_state = S_RESULT;
                        end
                    endcase
                end
            end

            S_DIV: begin
                n_rem  = div_ge ? Q_W'(div_trial - {1'b0, ppu_eff}) : div_trial[Q_W-1:0];
                n_divq = {r_divq[QW-2:0], div_ge};
                n_dcnt = r_dcnt + DCNT_W'(1);
                if (r_dcnt == DCNT_W'(QW - 1)) begin
                    n_state = S_SETUP;
                end
            end

            S_SETUP: begin
                n_min   = sat_q(64'(r_center_y) - $signed(64'(r_divq)));
                n_max   = sat_q(64'(r_center_y) + $signed(64'(r_divq)));
                n_r     = sat_q(64'(dcol) * 64'($signed({1'b0, r_upp}))
                                + 64'(r_center_x));
                n_state = S_MA;
            end

            // first multiply of a map step, previous result latched
            S_MA: begin
                n_z     = z_cur;
                n_p1    = 64'(z_cur) * 64'(r_r);
                n_rest  = sat_q(64'(Q_ONE) - 64'(z_cur));
                n_first = 1'b0;
                n_state = S_MB;
            end

            // second multiply, record check of the latched value, loop control
            S_MB: begin
                n_p2 = 64'(q1) * 64'(r_rest);
                if (r_last_rec) begin
                    if (in_win) begin
                        mb_recs = r_recs + CNT_W'(1);
                        n_miss  = '0;
                        n_pix_p = 1'b1;
                        n_prod  = 65'(mag) * 65'(ppu_eff);
                        n_neg   = d[Q_W];
                    end else if (r_miss > (LIM_W + 1)'(r_miss_limit)) begin
                        mb_recs = r_recs + CNT_W'(1);
                        n_miss  = '0;
                    end else begin
                        n_miss = r_miss + (LIM_W + 1)'(1);
                    end
                end
                n_recs = mb_recs;
                if (r_steps < r_warmup) begin
                    n_steps    = r_steps + CNT_W'(1);
                    n_last_rec = 1'b0;
                    n_state    = S_MA;
                end else if (mb_recs < r_rec_count) begin
                    n_last_rec = 1'b1;
                    n_state    = S_MA;
                end else begin
                    n_state = S_DRAIN;
                end
            end

            S_DRAIN: begin
                if (!r_pix_p && !r_pix_w) begin
                    n_res_p = r_drawn;
                    n_state = S_RESULT;
                end
            end

            S_READ: begin
                ram_addr = rd_addr;
                n_state  = S_READ_WAIT;
            end

            S_READ_WAIT: begin
                n_res_b = ram_rdata;
                n_state = S_RESULT;
            end

            S_RESULT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_b     = r_res_b;
                    n_out_p     = r_res_p;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // pixel update: read the old brightness, then write it back brighter
        if (r_pix_p) begin
            ram_addr = pix_addr;
            if (pix_in) begin
                n_pix_w = 1'b1;
                n_waddr = pix_addr;
                n_drawn = r_drawn + CNT_W'(1);
            end
        end
        if (r_pix_w) begin
            ram_we    = 1'b1;
            ram_addr  = r_waddr;
            ram_wdata = bright_next(ram_rdata);
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_clr_reply <= 1'b0;
            r_first     <= 1'b0;
            r_last_rec  <= 1'b0;
            r_steps     <= '0;
            r_recs      <= '0;
            r_drawn     <= '0;
            r_miss      <= '0;
            r_pix_p     <= 1'b0;
            r_pix_w     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_clr_addr  <= n_clr_addr;
            r_clr_reply <= n_clr_reply;
            r_first     <= n_first;
            r_last_rec  <= n_last_rec;
            r_steps     <= n_steps;
            r_recs      <= n_recs;
            r_drawn     <= n_drawn;
            r_miss      <= n_miss;
            r_pix_p     <= n_pix_p;
            r_pix_w     <= n_pix_w;
            r_out_valid <= n_out_valid;
        end
    end

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x   <= RST_CENTER_X;
            r_center_y   <= RST_CENTER_Y;
            r_ppu        <= RST_PPU;
            r_upp        <= RST_UPP;
            r_warmup     <= RST_WARMUP;
            r_rec_count  <= RST_REC_COUNT;
            r_miss_limit <= RST_MISS_LIMIT;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_CENTER_X:   r_center_x   <= i_cfg.data;
                CFG_CENTER_Y:   r_center_y   <= i_cfg.data;
                CFG_PPU:        r_ppu        <= i_cfg.data;
                CFG_UPP:        r_upp        <= i_cfg.data;
                CFG_WARMUP:     r_warmup     <= i_cfg.data[CNT_W-1:0];
                CFG_REC_COUNT:  r_rec_count  <= i_cfg.data[CNT_W-1:0];
                CFG_MISS_LIMIT: r_miss_limit <= i_cfg.data[LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_col   <= n_col;
        r_row   <= n_row;
        r_divq  <= n_divq;
        r_rem   <= n_rem;
        r_dcnt  <= n_dcnt;
        r_min   <= n_min;
        r_max   <= n_max;
        r_r     <= n_r;
        r_z     <= n_z;
        r_rest  <= n_rest;
        r_p1    <= n_p1;
        r_p2    <= n_p2;
        r_prod  <= n_prod;
        r_neg   <= n_neg;
        r_waddr <= n_waddr;
        r_res_b <= n_res_b;
        r_res_p <= n_res_p;
        r_out_b <= n_out_b;
        r_out_p <= n_out_p;
    end

    // the read and write halves of a pixel update never share a cycle
    a_pix_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pix_p && r_pix_w))
        else $error("pixel read and write collide on the image port");

    // the miss run stops one past the limit
    a_miss_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MB) |-> (r_miss <= (LIM_W + 1)'(r_miss_limit) + (LIM_W + 1)'(1)))
        else $error("miss run beyond its limit");

    // every drawn point is also a taken record
    a_drawn_recs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drawn <= r_recs)
        else $error("more points drawn than records taken");

    // one item in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !i_item.ready)
        else $error("item accepted while another is in work");

endmodule
`default_nettype wire
